[rtl/core/worst_fit_segment_allocator_macros.svh]
// assertion macros for the worst fit segment allocator
`ifndef WORST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define WORST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define WFSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfsa assertion failed");
`define WFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfsa assertion failed");
`else
`define WFSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define WFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/wfsa_pkg.sv]
// shared constants and types of the worst fit segment allocator
`timescale 1ns / 1ps
package wfsa_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_POOL_BITS    = 16;

    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic shift;
        logic load;
    } chain_ctl_t;

endpackage

[rtl/core/wfsa_req_if.sv]
// request channel of the allocator
`timescale 1ns / 1ps
interface wfsa_req_if #(
    parameter int POOL_BITS = wfsa_pkg::DEF_POOL_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [POOL_BITS:0]   request_size;
    logic [POOL_BITS-1:0] block_offset;

    modport source (output valid, output action, output request_size,
                    output block_offset, input ready);
    modport sink   (input valid, input action, input request_size,
                    input block_offset, output ready);
endinterface

[rtl/core/wfsa_rsp_if.sv]
// response channel of the allocator
`timescale 1ns / 1ps
interface wfsa_rsp_if #(
    parameter int POOL_BITS = wfsa_pkg::DEF_POOL_BITS,
    parameter int HOLE_W    = 7
);
    logic                          valid;
    logic                          ready;
    logic [wfsa_pkg::STATUS_W-1:0] status;
    logic [POOL_BITS-1:0]          granted_offset;
    logic [HOLE_W-1:0]             hole_count;
    logic [POOL_BITS:0]            allocated_bytes;
    logic [POOL_BITS:0]            largest_free;

    modport source (output valid, output status, output granted_offset,
                    output hole_count, output allocated_bytes,
                    output largest_free, input ready);
    modport sink   (input valid, input status, input granted_offset,
                    input hole_count, input allocated_bytes,
                    input largest_free, output ready);
endinterface

[rtl/core/worst_fit_segment_allocator.sv]
// Worst fit segment allocator: the segment table lives in a chain of
// MAX_SEGMENTS cells that shifts toward cell 0 and wraps through the sequencer.
// Every request steps through: accept, a full rotation of the chain to find
// the worst fit or the offset, decide, a second rotation that rewrites the
// table in place and counts holes, used bytes and the largest hole, and
// posting the response, which holds until any earlier response is taken.
// A new request is taken while the previous response still waits. A
// pool_size write reloads the table; after reset the table loads first and
// no request is taken while it loads.
`timescale 1ns / 1ps
`include "worst_fit_segment_allocator_macros.svh"
module worst_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = wfsa_pkg::DEF_MAX_SEGMENTS,
    parameter int POOL_BITS    = wfsa_pkg::DEF_POOL_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    wfsa_req_if.sink           req,
    wfsa_rsp_if.source         rsp,
    input  logic               cfg_we,
    input  logic [POOL_BITS:0] cfg_data
);
    localparam int EW = 2*POOL_BITS + 3;

    wfsa_pkg::chain_ctl_t ctl;
    logic [EW-1:0]        seed;
    logic [EW-1:0]        tail;
    logic [EW-1:0]        cell_q [MAX_SEGMENTS];

    wfsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .POOL_BITS    (POOL_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .ctl      (ctl),
        .seed     (seed),
        .tail     (tail),
        .head     (cell_q[0])
    );

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        logic [EW-1:0] nxt;
        logic [EW-1:0] cell_seed;

        if (i == MAX_SEGMENTS - 1)
        begin : g_last
            assign nxt = tail;
        end
        else
        begin : g_mid
            assign nxt = cell_q[i+1];
        end

        // only the first cell comes up holding the whole pool
        if (i == 0)
        begin : g_first
            assign cell_seed = seed;
        end
        else
        begin : g_rest
            assign cell_seed = '0;
        end

        wfsa_cell #(
            .EW (EW)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .seed  (cell_seed),
            .nxt   (nxt),
            .q     (cell_q[i])
        );
    end

    `WFSA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req.valid && req.ready, !req.ready)
    `WFSA_ASSERT_SAME(a_grant_only_ok, clk, rst_n, rsp.valid && (rsp.status != wfsa_pkg::ST_OK), rsp.granted_offset == '0)
    `WFSA_ASSERT_SAME(a_no_hole_no_free, clk, rst_n, rsp.valid && (rsp.hole_count == '0), rsp.largest_free == '0)
endmodule

[rtl/core/wfsa_cell.sv]
// one segment table cell of the shifting chain
`timescale 1ns / 1ps
module wfsa_cell #(
    parameter int EW = 35
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wfsa_pkg::chain_ctl_t ctl,
    input  logic [EW-1:0]        seed,
    input  logic [EW-1:0]        nxt,
    output logic [EW-1:0]        q
);
    logic          valid_reg;
    logic [EW-2:0] body_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= seed[EW-1];
        end
        else if (ctl.shift)
        begin
            valid_reg <= nxt[EW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            body_reg <= seed[EW-2:0];
        end
        else if (ctl.shift)
        begin
            body_reg <= nxt[EW-2:0];
        end
    end

    assign q = {valid_reg, body_reg};
endmodule

[rtl/core/wfsa_ctrl.sv]
// sequencer: scan pass, edit pass and result statistics
`timescale 1ns / 1ps
module wfsa_ctrl #(
    parameter int MAX_SEGMENTS = wfsa_pkg::DEF_MAX_SEGMENTS,
    parameter int POOL_BITS    = wfsa_pkg::DEF_POOL_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    wfsa_req_if.sink                   req,
    wfsa_rsp_if.source                 rsp,
    input  logic                       cfg_we,
    input  logic [POOL_BITS:0]         cfg_data,
    output wfsa_pkg::chain_ctl_t       ctl,
    output logic [2*POOL_BITS+2:0]     seed,
    output logic [2*POOL_BITS+2:0]     tail,
    input  logic [2*POOL_BITS+2:0]     head
);
    localparam int EW = 2*POOL_BITS + 3;
    localparam int LW = POOL_BITS + 1;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int TW = $clog2(MAX_SEGMENTS + 2);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_EDIT, S_DONE} state_t;
    typedef enum logic [1:0] {ED_NONE, ED_MARK, ED_SPLIT, ED_MERGE} edit_t;

    state_t                        state_reg;
    edit_t                         edit_reg;
    logic                          init_reg;
    logic [LW-1:0]                 pool_reg;
    logic [TW-1:0]                 t_reg;
    logic                          act_reg;
    logic [LW-1:0]                 req_reg;
    logic [POOL_BITS-1:0]          off_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          found_reg;
    logic [IW-1:0]                 best_idx_reg;
    logic [LW-1:0]                 best_len_reg;
    logic [POOL_BITS-1:0]          best_start_reg;
    logic                          hit_reg;
    logic                          rchk_reg;
    logic                          lft_reg;
    logic                          rgt_reg;
    logic [IW-1:0]                 base_idx_reg;
    logic [POOL_BITS-1:0]          base_start_reg;
    logic [LW-1:0]                 mlen_reg;
    logic [IW-1:0]                 pos_reg;
    logic [1:0]                    drop_reg;
    logic [EW-1:0]                 ent_a_reg;
    logic [EW-1:0]                 ent_b_reg;
    logic [EW-1:0]                 w1_reg;
    logic [EW-1:0]                 w2_reg;
    logic [EW-1:0]                 w3_reg;
    logic [wfsa_pkg::STATUS_W-1:0] status_reg;
    logic [POOL_BITS-1:0]          granted_reg;
    logic [CW-1:0]                 holes_reg;
    logic [LW-1:0]                 used_sum_reg;
    logic [LW-1:0]                 largest_reg;
    logic                          rsp_valid_reg;
    logic [wfsa_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [POOL_BITS-1:0]          rsp_granted_reg;
    logic [CW-1:0]                 rsp_holes_reg;
    logic [LW-1:0]                 rsp_used_reg;
    logic [LW-1:0]                 rsp_largest_reg;

    logic [LW-1:0]        pool_max;
    logic [LW-1:0]        cfg_clamped;
    logic [LW-1:0]        init_len;
    logic                 h_valid;
    logic                 h_used;
    logic [POOL_BITS-1:0] h_start;
    logic [LW-1:0]        h_len;
    logic                 fit;
    logic [TW-1:0]        j;
    logic [TW-1:0]        pos_ext;
    logic [EW-1:0]        o;
    logic                 o_valid;
    logic                 o_used;
    logic [LW-1:0]        o_len;
    logic [LW-1:0]        split_sum;

    assign pool_max    = LW'(1) << POOL_BITS;
    assign cfg_clamped = (cfg_data == '0) ? LW'(1) :
                         ((cfg_data > pool_max) ? pool_max : cfg_data);
    assign init_len    = cfg_we ? cfg_clamped : pool_reg;
    assign seed        = {1'b1, 1'b0, {POOL_BITS{1'b0}}, init_len};

    assign ctl.load  = cfg_we | init_reg;
    assign ctl.shift = (state_reg == S_SCAN) || (state_reg == S_EDIT);

    assign h_valid = head[EW-1];
    assign h_used  = head[EW-2];
    assign h_start = head[EW-3 -: POOL_BITS];
    assign h_len   = head[LW-1:0];

    assign fit = h_valid && !h_used && (h_len >= req_reg) &&
                 (!found_reg || (h_len > best_len_reg));

    assign j         = t_reg - TW'(2);
    assign pos_ext   = TW'(pos_reg);
    assign split_sum = {1'b0, best_start_reg} + req_reg;

    // output slot j of the edited table, built from the delayed copies w1, w2, w3 of the head
    always_comb
    begin
        o = '0;
        if (t_reg >= TW'(2))
        begin
            case (edit_reg)
                ED_NONE:  o = w2_reg;
                ED_MARK:  o = (j == pos_ext) ? ent_a_reg : w2_reg;
                ED_SPLIT:
                begin
                    if (j < pos_ext)
                        o = w2_reg;
                    else if (j == pos_ext)
                        o = ent_a_reg;
                    else if (j == pos_ext + TW'(1))
                        o = ent_b_reg;
                    else
                        o = w3_reg;
                end
                ED_MERGE:
                begin
                    if (j < pos_ext)
                        o = w2_reg;
                    else if (j == pos_ext)
                        o = ent_a_reg;
                    else
                    begin
                        case (drop_reg)
                            2'd0:    o = w2_reg;
                            2'd1:    o = w1_reg;
                            default: o = head;
                        endcase
                    end
                end
                default:  o = w2_reg;
            endcase
        end
    end

    assign o_valid = o[EW-1];
    assign o_used  = o[EW-2];
    assign o_len   = o[LW-1:0];
    assign tail    = (state_reg == S_EDIT) ? o : head;

    assign req.ready           = (state_reg == S_IDLE) && !init_reg;
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.granted_offset  = rsp_granted_reg;
    assign rsp.hole_count      = rsp_holes_reg;
    assign rsp.allocated_bytes = rsp_used_reg;
    assign rsp.largest_free    = rsp_largest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            edit_reg        <= ED_NONE;
            init_reg        <= 1'b1;
            pool_reg        <= LW'(1) << POOL_BITS;
            t_reg           <= '0;
            act_reg         <= wfsa_pkg::ACT_ALLOC;
            req_reg         <= '0;
            off_reg         <= '0;
            cnt_reg         <= '0;
            found_reg       <= 1'b0;
            best_idx_reg    <= '0;
            best_len_reg    <= '0;
            best_start_reg  <= '0;
            hit_reg         <= 1'b0;
            rchk_reg        <= 1'b0;
            lft_reg         <= 1'b0;
            rgt_reg         <= 1'b0;
            base_idx_reg    <= '0;
            base_start_reg  <= '0;
            mlen_reg        <= '0;
            pos_reg         <= '0;
            drop_reg        <= '0;
            ent_a_reg       <= '0;
            ent_b_reg       <= '0;
            w1_reg          <= '0;
            w2_reg          <= '0;
            w3_reg          <= '0;
            status_reg      <= wfsa_pkg::ST_OK;
            granted_reg     <= '0;
            holes_reg       <= '0;
            used_sum_reg    <= '0;
            largest_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= wfsa_pkg::ST_OK;
            rsp_granted_reg <= '0;
            rsp_holes_reg   <= '0;
            rsp_used_reg    <= '0;
            rsp_largest_reg <= '0;
        end
        else
        begin
            init_reg <= 1'b0;
            if (cfg_we)
            begin
                pool_reg <= cfg_clamped;
            end
            if (rsp_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        act_reg     <= req.action;
                        req_reg     <= req.request_size;
                        off_reg     <= req.block_offset;
                        t_reg       <= '0;
                        cnt_reg     <= '0;
                        found_reg   <= 1'b0;
                        hit_reg     <= 1'b0;
                        rchk_reg    <= 1'b0;
                        lft_reg     <= 1'b0;
                        rgt_reg     <= 1'b0;
                        granted_reg <= '0;
                        state_reg   <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    w1_reg  <= head;
                    cnt_reg <= cnt_reg + CW'(h_valid);
                    if (fit)
                    begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= t_reg[IW-1:0];
                        best_len_reg   <= h_len;
                        best_start_reg <= h_start;
                    end
                    // right neighbor of the freed segment passes in the next cycle
                    if (rchk_reg)
                    begin
                        rchk_reg <= 1'b0;
                        if (h_valid && !h_used)
                        begin
                            rgt_reg  <= 1'b1;
                            mlen_reg <= mlen_reg + h_len;
                        end
                    end
                    if (!hit_reg && h_valid && (h_start == off_reg))
                    begin
                        hit_reg  <= 1'b1;
                        rchk_reg <= 1'b1;
                        if ((t_reg != '0) && w1_reg[EW-1] && !w1_reg[EW-2])
                        begin
                            lft_reg        <= 1'b1;
                            base_idx_reg   <= IW'(t_reg - TW'(1));
                            base_start_reg <= w1_reg[EW-3 -: POOL_BITS];
                            mlen_reg       <= w1_reg[LW-1:0] + h_len;
                        end
                        else
                        begin
                            base_idx_reg   <= t_reg[IW-1:0];
                            base_start_reg <= h_start;
                            mlen_reg       <= h_len;
                        end
                    end
                    if (t_reg == TW'(MAX_SEGMENTS - 1))
                    begin
                        t_reg     <= '0;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        t_reg <= t_reg + TW'(1);
                    end
                end

                S_DECIDE:
                begin
                    edit_reg     <= ED_NONE;
                    holes_reg    <= '0;
                    used_sum_reg <= '0;
                    largest_reg  <= '0;
                    t_reg        <= '0;
                    state_reg    <= S_EDIT;
                    if (act_reg == wfsa_pkg::ACT_ALLOC)
                    begin
                        if (req_reg == '0)
                        begin
                            status_reg <= wfsa_pkg::ST_ZERO;
                        end
                        else if (!found_reg)
                        begin
                            status_reg <= wfsa_pkg::ST_NOSPACE;
                        end
                        else if (best_len_reg != req_reg)
                        begin
                            if (cnt_reg >= CW'(MAX_SEGMENTS))
                            begin
                                status_reg <= wfsa_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_reg  <= wfsa_pkg::ST_OK;
                                granted_reg <= best_start_reg;
                                edit_reg    <= ED_SPLIT;
                                pos_reg     <= best_idx_reg;
                                ent_a_reg   <= {1'b1, 1'b1, best_start_reg, req_reg};
                                ent_b_reg   <= {1'b1, 1'b0, split_sum[POOL_BITS-1:0],
                                                best_len_reg - req_reg};
                            end
                        end
                        else
                        begin
                            status_reg  <= wfsa_pkg::ST_OK;
                            granted_reg <= best_start_reg;
                            edit_reg    <= ED_MARK;
                            pos_reg     <= best_idx_reg;
                            ent_a_reg   <= {1'b1, 1'b1, best_start_reg, best_len_reg};
                        end
                    end
                    else
                    begin
                        if (!hit_reg)
                        begin
                            status_reg <= wfsa_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            status_reg <= wfsa_pkg::ST_OK;
                            edit_reg   <= ED_MERGE;
                            pos_reg    <= base_idx_reg;
                            drop_reg   <= {1'b0, lft_reg} + {1'b0, rgt_reg};
                            ent_a_reg  <= {1'b1, 1'b0, base_start_reg, mlen_reg};
                        end
                    end
                end

                S_EDIT:
                begin
                    w1_reg <= head;
                    w2_reg <= w1_reg;
                    w3_reg <= w2_reg;
                    if (o_valid)
                    begin
                        if (o_used)
                        begin
                            used_sum_reg <= used_sum_reg + o_len;
                        end
                        else
                        begin
                            holes_reg <= holes_reg + CW'(1);
                            if (o_len > largest_reg)
                            begin
                                largest_reg <= o_len;
                            end
                        end
                    end
                    if (t_reg == TW'(MAX_SEGMENTS + 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        t_reg <= t_reg + TW'(1);
                    end
                end

                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg   <= 1'b1;
                        rsp_status_reg  <= status_reg;
                        rsp_granted_reg <= granted_reg;
                        rsp_holes_reg   <= holes_reg;
                        rsp_used_reg    <= used_sum_reg;
                        rsp_largest_reg <= largest_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
